// File: design/sseq_pkg.sv
package sseq_pkg;

  localparam int NORM_W = 16;
  localparam int MAG_W = 16;
  localparam int SQ_W = 2 * MAG_W;
  localparam int LEN_W = SQ_W + 1;
  localparam int M_W = 15;
  localparam int M_TOP = M_W - 1;
  localparam int BIT_W = 4;
  localparam int ACC_W = 68;
  localparam int BS_SH = M_TOP + 2;
  localparam int L2_SH = 2 * M_TOP + 2;
  localparam int Q14_SH = 14;
  localparam int ROUND_Q14 = 8192;
  localparam int LW_W = 14;
  localparam int HALF_W = LW_W - 1;
  localparam int OFS_W = 15;
  localparam logic [LW_W-1:0] LW_RESET = 14'd66;
  localparam int VTX_IDX_W = 2;
  localparam logic [VTX_IDX_W-1:0] LAST_IDX = 2'd3;

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [OFS_W-1:0]  ox;
    logic signed [OFS_W-1:0]  oy;
  } seg_t;

endpackage

// File: design/sseq_mul.sv
module sseq_mul (
  input  logic                        clk,
  input  logic [sseq_pkg::MAG_W-1:0]  a,
  input  logic [sseq_pkg::MAG_W-1:0]  b,
  output logic [sseq_pkg::SQ_W-1:0]   p
);
  import sseq_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: design/sseq_srch.sv
module sseq_srch (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sseq_pkg::LEN_W-1:0]  len,
  input  logic [sseq_pkg::SQ_W-1:0]   dsq,
  output logic                        done,
  output logic [sseq_pkg::M_W-1:0]    m
);
  import sseq_pkg::*;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] bs;
  logic signed [ACC_W-1:0] l2;
  logic signed [ACC_W-1:0] rhs;
  logic signed [ACC_W-1:0] trial;
  logic [BIT_W-1:0] bit_idx;
  logic busy;
  logic ok;

  // trial = (2*cand - 1)^2 * len, built up from running terms
  always_comb begin
    trial = acc + bs + l2;
    ok = (trial <= rhs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bit_idx == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= $signed(ACC_W'(len));
      bs <= -($signed(ACC_W'(len)) <<< BS_SH);
      l2 <= $signed(ACC_W'(len)) <<< L2_SH;
      rhs <= $signed(ACC_W'(dsq)) <<< L2_SH;
      m <= '0;
      bit_idx <= BIT_W'(M_TOP);
    end else if (busy) begin
      if (ok) begin
        acc <= trial;
        m[bit_idx] <= 1'b1;
        bs <= (bs >>> 1) + l2;
      end else begin
        bs <= bs >>> 1;
      end
      l2 <= l2 >>> 2;
      bit_idx <= bit_idx - 1'b1;
    end
  end

endmodule

// File: design/sseq_vtx.sv
module sseq_vtx #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  output logic                                free,
  input  logic signed [COORD_WIDTH-1:0]       prev_x,
  input  logic signed [COORD_WIDTH-1:0]       prev_y,
  input  logic signed [COORD_WIDTH-1:0]       cur_x,
  input  logic signed [COORD_WIDTH-1:0]       cur_y,
  input  sseq_pkg::seg_t                      seg,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_WIDTH-1:0]       vertex_x,
  output logic signed [COORD_WIDTH-1:0]       vertex_y,
  output logic signed [sseq_pkg::NORM_W-1:0]  normal_x,
  output logic signed [sseq_pkg::NORM_W-1:0]  normal_y,
  output logic                                last_of_run
);
  import sseq_pkg::*;

  localparam int SW = ((COORD_WIDTH > OFS_W) ? COORD_WIDTH : OFS_W) + 1;
  localparam logic signed [SW-1:0] CMAX =
    {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = ~CMAX;

  logic busy;
  logic [VTX_IDX_W-1:0] idx;
  logic signed [COORD_WIDTH-1:0] px, py, cx, cy;
  seg_t sg;

  logic plus;
  logic signed [COORD_WIDTH-1:0] bx, by;
  logic signed [OFS_W-1:0] ofx, ofy;
  logic signed [SW-1:0] sum_x, sum_y;

  always_comb begin
    plus = !idx[0];
    bx = idx[1] ? cx : px;
    by = idx[1] ? cy : py;
    ofx = plus ? sg.ox : -sg.ox;
    ofy = plus ? sg.oy : -sg.oy;
    sum_x = SW'(bx) + SW'(ofx);
    sum_y = SW'(by) + SW'(ofy);
    if (sum_x > CMAX) begin
      vertex_x = CMAX[COORD_WIDTH-1:0];
    end else if (sum_x < CMIN) begin
      vertex_x = CMIN[COORD_WIDTH-1:0];
    end else begin
      vertex_x = sum_x[COORD_WIDTH-1:0];
    end
    if (sum_y > CMAX) begin
      vertex_y = CMAX[COORD_WIDTH-1:0];
    end else if (sum_y < CMIN) begin
      vertex_y = CMIN[COORD_WIDTH-1:0];
    end else begin
      vertex_y = sum_y[COORD_WIDTH-1:0];
    end
    normal_x = plus ? sg.nx : -sg.nx;
    normal_y = plus ? sg.ny : -sg.ny;
    last_of_run = (idx == LAST_IDX);
    out_valid = busy;
    free = !busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (busy && out_ready) begin
      idx <= idx + 1'b1;
      if (idx == LAST_IDX) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px <= prev_x;
      py <= prev_y;
      cx <= cur_x;
      cy <= cur_y;
      sg <= seg;
    end
  end

endmodule

// File: design/stroke_segment_quad_expander.sv
// Thick-line quad expander for pen strokes, with normals in signed Q1.14. A
// commit and the first point of a stroke are taken without leaving the idle state
// and give no vertices. A point that closes a segment holds in_ready low from
// when it is taken until its segment is handed on. It passes through the
// registered difference, the pre-scaling shifts (none at COORD_WIDTH 16, one per
// bit of |dx| or |dy| beyond 16 bits otherwise), the squared length on the shared
// 16x16 multiplier, two passes (15 bit steps) of the shift-add-compare search for
// the rounded Q1.14 normal, the offsets and the hand-off. A point equal to the
// previous one skips both search passes. The four vertices then leave from the
// output stage one per cycle with out_ready high, while the next item is already
// taken; a segment finished before the previous quad has drained waits in place.
// line_width is taken at any time cfg_valid is high.
module stroke_segment_quad_expander #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sseq_pkg::LW_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                action,
  input  logic signed [COORD_WIDTH-1:0]       point_x,
  input  logic signed [COORD_WIDTH-1:0]       point_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_WIDTH-1:0]       vertex_x,
  output logic signed [COORD_WIDTH-1:0]       vertex_y,
  output logic signed [sseq_pkg::NORM_W-1:0]  normal_x,
  output logic signed [sseq_pkg::NORM_W-1:0]  normal_y,
  output logic                                last_of_run
);
  import sseq_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int MW = (DW > MAG_W + 1) ? DW : MAG_W + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCALE = 4'd1;
  localparam logic [3:0] S_SQX   = 4'd2;
  localparam logic [3:0] S_SQY   = 4'd3;
  localparam logic [3:0] S_LEN   = 4'd4;
  localparam logic [3:0] S_INIT  = 4'd5;
  localparam logic [3:0] S_WAIT  = 4'd6;
  localparam logic [3:0] S_OX    = 4'd7;
  localparam logic [3:0] S_OY    = 4'd8;
  localparam logic [3:0] S_OYD   = 4'd9;
  localparam logic [3:0] S_HAND  = 4'd10;

  logic [3:0] state;
  logic [LW_W-1:0] line_width;
  logic stroke_active;
  logic segment_emitted;
  logic signed [COORD_WIDTH-1:0] prev_x, prev_y, cur_x, cur_y;
  logic [MW-1:0] magx, magy;
  logic sx_neg, sy_pos;
  logic [SQ_W-1:0] sqx, sqy;
  logic [LEN_W-1:0] len;
  logic comp;
  logic [M_W-1:0] mx, my;
  logic [OFS_W-2:0] oxm, oym;

  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0] adx, ady;
  logic big;
  logic [MAG_W-1:0] ax, ay;
  logic [MAG_W-1:0] mul_a, mul_b;
  logic [SQ_W-1:0] mul_p;
  logic [SQ_W-1:0] prod_rnd;
  logic [HALF_W-1:0] half;
  logic srch_start, srch_done;
  logic [M_W-1:0] srch_m;
  logic [SQ_W-1:0] dsq;
  logic vtx_free, vtx_load;
  seg_t seg;

  always_comb begin
    dx = {point_x[COORD_WIDTH-1], point_x} - {prev_x[COORD_WIDTH-1], prev_x};
    dy = {point_y[COORD_WIDTH-1], point_y} - {prev_y[COORD_WIDTH-1], prev_y};
    adx = dx[DW-1] ? -dx : dx;
    ady = dy[DW-1] ? -dy : dy;
    big = (|magx[MW-1:MAG_W]) || (|magy[MW-1:MAG_W]);
    ax = magx[MAG_W-1:0];
    ay = magy[MAG_W-1:0];
    half = line_width[LW_W-1:1];
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX: begin
        mul_a = ax;
        mul_b = ax;
      end
      S_SQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      S_OX: begin
        mul_a = MAG_W'(mx);
        mul_b = MAG_W'(half);
      end
      S_OY: begin
        mul_a = MAG_W'(my);
        mul_b = MAG_W'(half);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_rnd = mul_p + SQ_W'(ROUND_Q14);
    srch_start = (state == S_INIT);
    dsq = comp ? sqx : sqy;
    in_ready = (state == S_IDLE);
    cfg_ready = 1'b1;
    vtx_load = (state == S_HAND) && vtx_free;
    seg.nx = sy_pos ? -NORM_W'(mx) : NORM_W'(mx);
    seg.ny = sx_neg ? -NORM_W'(my) : NORM_W'(my);
    seg.ox = sy_pos ? -OFS_W'(oxm) : OFS_W'(oxm);
    seg.oy = sx_neg ? -OFS_W'(oym) : OFS_W'(oym);
  end

  sseq_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  sseq_srch u_srch (
    .clk   (clk),
    .rst   (rst),
    .start (srch_start),
    .len   (len),
    .dsq   (dsq),
    .done  (srch_done),
    .m     (srch_m)
  );

  sseq_vtx #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_vtx (
    .clk         (clk),
    .rst         (rst),
    .load        (vtx_load),
    .free        (vtx_free),
    .prev_x      (prev_x),
    .prev_y      (prev_y),
    .cur_x       (cur_x),
    .cur_y       (cur_y),
    .seg         (seg),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .last_of_run (last_of_run)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      line_width <= LW_RESET;
      stroke_active <= 1'b0;
      segment_emitted <= 1'b0;
      prev_x <= '0;
      prev_y <= '0;
      comp <= 1'b0;
    end else begin
      if (cfg_valid) begin
        line_width <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (action) begin
              if (stroke_active && segment_emitted) begin
                stroke_active <= 1'b0;
                segment_emitted <= 1'b0;
              end
            end else if (!stroke_active) begin
              prev_x <= point_x;
              prev_y <= point_y;
              stroke_active <= 1'b1;
            end else begin
              state <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          if (!big) begin
            state <= S_SQX;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: state <= S_LEN;
        S_LEN: begin
          comp <= 1'b0;
          state <= (ax == '0 && ay == '0) ? S_OX : S_INIT;
        end
        S_INIT: state <= S_WAIT;
        S_WAIT: begin
          if (srch_done) begin
            if (!comp) begin
              comp <= 1'b1;
              state <= S_INIT;
            end else begin
              state <= S_OX;
            end
          end
        end
        S_OX:  state <= S_OY;
        S_OY:  state <= S_OYD;
        S_OYD: state <= S_HAND;
        S_HAND: begin
          if (vtx_free) begin
            prev_x <= cur_x;
            prev_y <= cur_y;
            segment_emitted <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur_x <= point_x;
        cur_y <= point_y;
        magx <= MW'(adx);
        magy <= MW'(ady);
        sx_neg <= dx[DW-1];
        sy_pos <= !dy[DW-1] && (dy != '0);
      end
      S_SCALE: begin
        if (big) begin
          magx <= magx >> 1;
          magy <= magy >> 1;
        end
      end
      S_SQY: sqx <= mul_p;
      S_LEN: begin
        sqy <= mul_p;
        len <= LEN_W'(sqx) + LEN_W'(mul_p);
        mx <= '0;
        my <= '0;
      end
      S_WAIT: begin
        if (srch_done) begin
          if (!comp) begin
            mx <= srch_m;
          end else begin
            my <= srch_m;
          end
        end
      end
      S_OY:  oxm <= prod_rnd[Q14_SH +: OFS_W-1];
      S_OYD: oym <= prod_rnd[Q14_SH +: OFS_W-1];
      default: begin
      end
    endcase
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    srch_done |-> state == S_WAIT)
    else $error("normal search finished outside its wait state");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    srch_done |-> srch_m <= M_W'(16384))
    else $error("normal magnitude above one");

  a_emit_active: assert property (@(posedge clk) disable iff (rst)
    segment_emitted |-> stroke_active)
    else $error("segment flag set with no active stroke");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    state == S_HAND && !vtx_free |=> state == S_HAND)
    else $error("segment left hand-off before output stage was free");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sseq_pkg::*;

  localparam int COORD_W = 16;
  localparam int SETTLE_CYCLES = 60;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PHASE_POINTS = 60;
  localparam int NUM_PHASES = 5;
  localparam logic ACT_POINT = 1'b0;
  localparam logic ACT_COMMIT = 1'b1;
  localparam logic [LW_W-1:0] LW_MAX = {LW_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic                      last;
  } vertex_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NO_VERTEX, ROW_QUAD} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic                      act;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    vertex_t [0:3]             quad;
  } row_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [LW_W-1:0]           cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      action;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic signed [NORM_W-1:0]  normal_x;
  logic signed [NORM_W-1:0]  normal_y;
  logic                      last_of_run;

  // shadow of the block state
  logic [LW_W-1:0] width_reg;
  longint          pen_x;
  longint          pen_y;
  bit              drawing;
  bit              has_segment;

  vertex_t vertex_q[$];
  vertex_t want;
  row_t    steps[$];
  int      errors;
  int      items_sent;
  int      vertices_checked;
  int      widths_used;
  bit      idle_on;

  stroke_segment_quad_expander #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .point_x(point_x),
    .point_y(point_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .vertex_x(vertex_x),
    .vertex_y(vertex_y),
    .normal_x(normal_x),
    .normal_y(normal_y),
    .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    if (errors < 30) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    errors++;
  endtask

  function automatic logic signed [COORD_W-1:0] sat_coord(input longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return COORD_W'(v);
  endfunction

  // largest m in [0, 1.0 Q14] with (2m-1)^2 * len2 <= d^2 * 2^30
  function automatic longint norm_mag(input longint unsigned d, input longint unsigned len2);
    longint unsigned lo, hi, mid, t, rhs;
    lo = 0;
    hi = 1 << Q14_SH;
    rhs = (d * d) << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      t = 2 * mid - 1;
      if (t * t * len2 <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return longint'(lo);
  endfunction

  function automatic longint scale_offset(input longint n, input longint half);
    longint m;
    m = ((n < 0 ? -n : n) * half + ROUND_Q14) >>> Q14_SH;
    return n < 0 ? -m : m;
  endfunction

  function automatic int expand_item(input logic act, input logic signed [COORD_W-1:0] px,
                                     input logic signed [COORD_W-1:0] py,
                                     output vertex_t [0:3] quad);
    longint dx, dy, nx, ny, ox, oy, half, cx, cy;
    longint unsigned ax, ay;
    quad = '0;
    nx = 0;
    ny = 0;
    cx = longint'(px);
    cy = longint'(py);
    if (act == ACT_COMMIT) begin
      if (drawing && has_segment) begin
        drawing = 0;
        has_segment = 0;
      end
      return 0;
    end
    if (!drawing) begin
      pen_x = cx;
      pen_y = cy;
      drawing = 1;
      return 0;
    end
    dx = cx - pen_x;
    dy = cy - pen_y;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    while (ax >= 65536 || ay >= 65536) begin
      ax = ax >> 1;
      ay = ay >> 1;
    end
    if (ax != 0 || ay != 0) begin
      nx = norm_mag(ay, ax * ax + ay * ay);
      ny = norm_mag(ax, ax * ax + ay * ay);
      if (dy > 0) begin
        nx = -nx;
      end
      if (dx < 0) begin
        ny = -ny;
      end
    end
    half = longint'(width_reg >> 1);
    ox = scale_offset(nx, half);
    oy = scale_offset(ny, half);
    quad[0] = '{sat_coord(pen_x + ox), sat_coord(pen_y + oy), NORM_W'(nx), NORM_W'(ny), 1'b0};
    quad[1] = '{sat_coord(pen_x - ox), sat_coord(pen_y - oy), NORM_W'(-nx), NORM_W'(-ny), 1'b0};
    quad[2] = '{sat_coord(cx + ox), sat_coord(cy + oy), NORM_W'(nx), NORM_W'(ny), 1'b0};
    quad[3] = '{sat_coord(cx - ox), sat_coord(cy - oy), NORM_W'(-nx), NORM_W'(-ny), 1'b1};
    pen_x = cx;
    pen_y = cy;
    has_segment = 1;
    return 4;
  endfunction

  function automatic vertex_t vtx(input int x, input int y, input int nx, input int ny,
                                  input int last);
    return '{COORD_W'(x), COORD_W'(y), NORM_W'(nx), NORM_W'(ny), 1'(last)};
  endfunction

  function automatic row_t plain_row(input row_kind_t kind, input logic act, input int x,
                                     input int y);
    row_t r;
    r = '0;
    r.kind = kind;
    r.act = act;
    r.x = COORD_W'(x);
    r.y = COORD_W'(y);
    return r;
  endfunction

  function automatic row_t quad_row(input int x, input int y, input vertex_t a,
                                    input vertex_t b, input vertex_t c, input vertex_t d);
    row_t r;
    r = plain_row(ROW_QUAD, ACT_POINT, x, y);
    r.quad = '{a, b, c, d};
    return r;
  endfunction

  task automatic add_row(input row_t r);
    steps = {steps, r};
  endtask

  function automatic logic signed [COORD_W-1:0] step_of();
    int mag;
    mag = $urandom & ((1 << $urandom_range(0, 15)) - 1);
    return $urandom_range(1) ? COORD_W'(-mag) : COORD_W'(mag);
  endfunction

  task automatic send_item(input logic act, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y, input row_kind_t kind,
                           input vertex_t [0:3] typed);
    vertex_t [0:3] quad;
    int n;
    while (idle_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    point_x <= x;
    point_y <= y;
    @(negedge clk);
    while (!in_ready) begin
      @(negedge clk);
    end
    @(posedge clk);
    items_sent++;
    n = expand_item(act, x, y, quad);
    if (kind == ROW_QUAD) begin
      quad = typed;
    end
    if (kind != ROW_NO_VERTEX) begin
      for (int i = 0; i < n; i++) begin
        vertex_q = {vertex_q, quad[i]};
      end
    end
  endtask

  // hold the sender until every pending vertex has left
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (vertex_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_line_width(input logic [LW_W-1:0] value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_ready) begin
      @(negedge clk);
    end
    @(posedge clk);
    width_reg = value;
    widths_used++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic draw_strokes(input int n_points);
    int done, segs;
    logic signed [COORD_W-1:0] sx, sy;
    done = 0;
    while (done < n_points) begin
      if ($urandom_range(39) == 0) begin
        hold_until_drained();
      end
      if ($urandom_range(1) == 0) begin
        sx = COORD_W'($urandom);
        sy = COORD_W'($urandom);
      end else begin
        sx = step_of();
        sy = step_of();
      end
      send_item(ACT_POINT, sx, sy, ROW_PREDICT, '0);
      done++;
      segs = $urandom_range(1, 8);
      for (int k = 0; k < segs; k++) begin
        case ($urandom_range(9))
          0: begin
          end
          1: begin
            sx = COORD_W'($urandom);
            sy = COORD_W'($urandom);
          end
          2: begin
            send_item(ACT_COMMIT, COORD_W'($urandom), COORD_W'($urandom), ROW_PREDICT, '0);
          end
          default: begin
            sx = sx + step_of();
            sy = sy + step_of();
          end
        endcase
        send_item(ACT_POINT, sx, sy, ROW_PREDICT, '0);
        done++;
      end
      if ($urandom_range(9) != 0) begin
        send_item(ACT_COMMIT, COORD_W'($urandom), COORD_W'($urandom), ROW_PREDICT, '0);
      end
      if ($urandom_range(9) == 0) begin
        send_item(ACT_COMMIT, COORD_W'($urandom), COORD_W'($urandom), ROW_PREDICT, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= !idle_on || $urandom_range(99) >= 38;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (vertex_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected vertex (%0d,%0d)", vertex_x, vertex_y));
      end else begin
        want = vertex_q.pop_front();
        if (vertex_x !== want.x || vertex_y !== want.y || normal_x !== want.nx ||
            normal_y !== want.ny || last_of_run !== want.last) begin
          flag_mismatch($sformatf(
            "vertex %0d: got (%0d,%0d) n(%0d,%0d) l%b want (%0d,%0d) n(%0d,%0d) l%b",
            vertices_checked, vertex_x, vertex_y, normal_x, normal_y, last_of_run,
            want.x, want.y, want.nx, want.ny, want.last));
        end
      end
      vertices_checked++;
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int waited;
    clk = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    action = ACT_POINT;
    point_x = '0;
    point_y = '0;
    errors = 0;
    items_sent = 0;
    vertices_checked = 0;
    widths_used = 1;
    idle_on = 1;
    width_reg = LW_RESET;
    pen_x = 0;
    pen_y = 0;
    drawing = 0;
    has_segment = 0;

    // half width is 33 at the reset width
    add_row(plain_row(ROW_NO_VERTEX, ACT_COMMIT, 0, 0));
    add_row(plain_row(ROW_NO_VERTEX, ACT_POINT, 0, 0));
    add_row(plain_row(ROW_NO_VERTEX, ACT_COMMIT, 0, 0));
    add_row(quad_row(100, 0, vtx(0, 33, 0, 16384, 0), vtx(0, -33, 0, -16384, 0),
                     vtx(100, 33, 0, 16384, 0), vtx(100, -33, 0, -16384, 1)));
    add_row(quad_row(100, 0, vtx(100, 0, 0, 0, 0), vtx(100, 0, 0, 0, 0),
                     vtx(100, 0, 0, 0, 0), vtx(100, 0, 0, 0, 1)));
    add_row(quad_row(100, -200, vtx(133, 0, 16384, 0, 0), vtx(67, 0, -16384, 0, 0),
                     vtx(133, -200, 16384, 0, 0), vtx(67, -200, -16384, 0, 1)));
    add_row(plain_row(ROW_NO_VERTEX, ACT_COMMIT, 0, 0));
    add_row(plain_row(ROW_NO_VERTEX, ACT_COMMIT, -1, -1));
    add_row(plain_row(ROW_NO_VERTEX, ACT_POINT, 32767, 32767));
    add_row(plain_row(ROW_PREDICT, ACT_POINT, -32768, -32768));
    add_row(plain_row(ROW_PREDICT, ACT_POINT, 32767, -32768));
    add_row(plain_row(ROW_PREDICT, ACT_POINT, -32768, 32767));
    add_row(plain_row(ROW_PREDICT, ACT_POINT, -32768, 32767));
    add_row(plain_row(ROW_PREDICT, ACT_POINT, -32767, 32767));
    add_row(plain_row(ROW_PREDICT, ACT_POINT, 0, 1));
    add_row(plain_row(ROW_PREDICT, ACT_POINT, 3, 4));
    add_row(plain_row(ROW_PREDICT, ACT_POINT, 3, 32767));
    add_row(plain_row(ROW_NO_VERTEX, ACT_COMMIT, 0, 0));
    add_row(plain_row(ROW_NO_VERTEX, ACT_POINT, -5, 7));
    add_row(plain_row(ROW_PREDICT, ACT_POINT, -5, 7));
    add_row(plain_row(ROW_PREDICT, ACT_POINT, -21846, 21845));
    add_row(plain_row(ROW_NO_VERTEX, ACT_COMMIT, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      send_item(steps[i].act, steps[i].x, steps[i].y, steps[i].kind, steps[i].quad);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: write_line_width(LW_MAX);
        1: write_line_width('0);
        2: write_line_width(14'd1);
        3: write_line_width(LW_W'($urandom));
        default: write_line_width(LW_MAX - 1'b1);
      endcase
      idle_on = (p != 2);
      draw_strokes(PHASE_POINTS);
    end

    in_valid <= 1'b0;
    idle_on = 1;
    waited = 0;
    while (vertex_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (vertex_q.size() != 0) begin
      flag_mismatch($sformatf("%0d vertices never arrived", vertex_q.size()));
    end

    $display("Sent %0d items (points and commits) over %0d line widths, zero to full scale.",
             items_sent, widths_used);
    $display("Checked %0d vertices; %0d mismatches.", vertices_checked, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/sseq_pkg.sv
design/sseq_mul.sv
design/sseq_srch.sv
design/sseq_vtx.sv
design/stroke_segment_quad_expander.sv
sim/tb_top.sv
